[rtl/core/ctcgd_pkg.sv]
// ctcgd_pkg: constants, exp tables and controller/datapath link types
// for the CTC greedy decoder. No dependencies.
`timescale 1ns / 1ps
package ctcgd_pkg;

    localparam int MAX_CLASSES     = 16;
    localparam int LOGIT_FRAC_BITS = 8;
    localparam int CLS_W           = 4;
    localparam int LOGIT_W         = 16;
    localparam int SUM_W           = 24;
    localparam int PSUM_W          = 25;
    localparam int CNT_W           = 9;
    localparam int PROB_W          = 16;
    localparam int EXP_W           = 17;
    localparam int PREV_W          = 5;
    localparam int DIVN_W          = 33;
    localparam int DSTEP_W         = 6;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]   ONE_Q16   = 24'd65536;
    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [PREV_W-1:0]  PREV_NONE = {PREV_W{1'b1}};
    localparam logic [DSTEP_W-1:0] DIV_STEPS = 6'd33;
    localparam logic [PROB_W-1:0]  PROB_MAX  = {PROB_W{1'b1}};

    // exp(-i) for integer part i < 12, Q1.16
    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] i);
        logic [EXP_W-1:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-f/16), Q1.16
    function automatic logic [EXP_W-1:0] exp_frac(input logic [3:0] f);
        logic [EXP_W-1:0] v;
        case (f)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic capture;
        logic mul_exp;
        logic update;
        logic div_char;
        logic div_mean;
        logic row_close;
        logic put_char;
        logic put_sum;
    } t_cmd;

    typedef struct packed {
        logic row_done;
        logic seq_end;
        logic emit;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

[rtl/core/ctcgd_ctrl.sv]
// ctcgd_ctrl: sequencing state machine of the CTC greedy decoder.
// Depends on ctcgd_pkg.
`timescale 1ns / 1ps
module ctcgd_ctrl import ctcgd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXP   = 8'b0000_0010,
        S_UPD   = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_DIVC  = 8'b0001_0000,
        S_PUTC  = 8'b0010_0000,
        S_MEANS = 8'b0100_0000,
        S_DIVM  = 8'b1000_0000
    } t_state_a;

    typedef enum logic [1:0] {
        P_NONE = 2'b01,
        P_SUM  = 2'b10
    } t_sum_state;

    t_state_a   r_state, n_state;
    t_sum_state r_psum_st, n_psum_st;

    assign o_in_ready = (r_state == S_IDLE) && (r_psum_st == P_NONE);

    always_comb begin
        n_state   = r_state;
        n_psum_st = r_psum_st;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (r_psum_st == P_SUM) begin
                    if (!i_stat.div_busy && i_stat.out_free) begin
                        o_cmd.put_sum = 1'b1;
                        n_psum_st     = P_NONE;
                    end
                end else if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.mul_exp = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.row_done) begin
                    n_state = S_IDLE;
                end else if (i_stat.emit) begin
                    o_cmd.div_char = 1'b1;
                    n_state        = S_DIVC;
                end else begin
                    o_cmd.row_close = 1'b1;
                    n_state         = i_stat.seq_end ? S_MEANS : S_IDLE;
                end
            end
            S_DIVC: begin
                if (!i_stat.div_busy) begin
                    n_state = S_PUTC;
                end
            end
            S_PUTC: begin
                if (i_stat.out_free) begin
                    o_cmd.put_char = 1'b1;
                    n_state        = i_stat.seq_end ? S_MEANS : S_IDLE;
                end
            end
            S_MEANS: begin
                o_cmd.div_mean = 1'b1;
                n_state        = S_DIVM;
            end
            S_DIVM: begin
                n_state   = S_IDLE;
                n_psum_st = P_SUM;
            end
            default: begin
                n_state   = S_IDLE;
                n_psum_st = P_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_psum_st <= P_NONE;
        end else begin
            r_state   <= n_state;
            r_psum_st <= n_psum_st;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_stat.div_busy)
        else $error("request accepted while divider busy");
    a_put_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.put_char || o_cmd.put_sum) |-> (!i_stat.div_busy && i_stat.out_free))
        else $error("result loaded before divider finished or output free");
    a_mean_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_mean |-> $past(o_cmd.put_char || o_cmd.row_close))
        else $error("mean division started without row close");

endmodule

[rtl/core/ctcgd_dp.sv]
// ctcgd_dp: datapath of the CTC greedy decoder: max/argmax, softmax
// normaliser, shared restoring divider, output register. Depends on ctcgd_pkg.
`timescale 1ns / 1ps
module ctcgd_dp import ctcgd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CLS_W-1:0]          i_cfg_data,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_row_end,
    input  logic                      i_sequence_end,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [CLS_W-1:0]          o_class_index,
    output logic [PROB_W-1:0]         o_char_probability,
    output logic [PROB_W-1:0]         o_mean_confidence,
    output logic [CNT_W-1:0]          o_emitted_count,
    output logic                      o_last
);

    logic [CLS_W-1:0]          r_blank;
    logic signed [LOGIT_W-1:0] r_x;
    logic                      r_row_done, r_seq_end;
    logic signed [LOGIT_W-1:0] r_row_max;
    logic [CLS_W-1:0]          r_argmax, r_cc;
    logic [SUM_W-1:0]          r_sum;
    logic [PREV_W-1:0]         r_prev;
    logic [PSUM_W-1:0]         r_psum;
    logic [CNT_W-1:0]          r_cnt;
    logic [EXP_W-1:0]          r_e;
    logic [SUM_W-1:0]          r_rem;
    logic [DIVN_W-1:0]         r_num;
    logic [SUM_W-1:0]          r_den;
    logic [DSTEP_W-1:0]        r_dstep;
    logic                      r_ovalid;

    logic                      fresh, gt;
    logic [LOGIT_W:0]          diff;
    logic [LOGIT_W:0]          q;
    logic [LOGIT_W-4:0]        ip;
    logic [2*EXP_W-1:0]        eprod;
    logic [EXP_W-1:0]          e_val;
    logic [SUM_W+EXP_W-1:0]    sprod;
    logic [SUM_W+1:0]          s_up;
    logic [SUM_W-1:0]          s_sat;
    logic [CLS_W:0]            cc_inc;
    logic [SUM_W:0]            rem_sh;
    logic                      qbit;
    logic [PROB_W-1:0]         q_sat;
    logic [PSUM_W:0]           mean_num;

    assign fresh = (r_sum == '0);
    assign gt    = r_x > r_row_max;
    assign diff  = gt ? ({r_x[LOGIT_W-1], r_x} - {r_row_max[LOGIT_W-1], r_row_max})
                      : ({r_row_max[LOGIT_W-1], r_row_max} - {r_x[LOGIT_W-1], r_x});
    assign q     = diff >> (LOGIT_FRAC_BITS - 4);
    assign ip    = q[LOGIT_W:4];
    assign eprod = exp_int(ip[3:0]) * exp_frac(q[3:0]);
    assign e_val = (ip >= (LOGIT_W-3)'(12)) ? '0 : EXP_W'((eprod + 34'd32768) >> 16);

    assign sprod = r_sum * r_e;
    always_comb begin
        if (gt) begin
            s_up = (SUM_W+2)'((sprod + 41'd32768) >> 16) + (SUM_W+2)'(ONE_Q16);
        end else begin
            s_up = (SUM_W+2)'(r_sum) + (SUM_W+2)'(r_e);
        end
        s_sat = (s_up > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : s_up[SUM_W-1:0];
    end
    assign cc_inc = {1'b0, r_cc} + (CLS_W+1)'(1);

    assign rem_sh = {r_rem, r_num[DIVN_W-1]};
    assign qbit   = rem_sh >= {1'b0, r_den};
    assign q_sat  = (r_num[DIVN_W-1:PROB_W] != '0) ? PROB_MAX : r_num[PROB_W-1:0];
    assign mean_num = (PSUM_W+1)'(r_psum) + (PSUM_W+1)'(r_cnt >> 1);

    assign o_stat.row_done = r_row_done;
    assign o_stat.seq_end  = r_seq_end;
    assign o_stat.emit     = ({1'b0, r_argmax} != {1'b0, r_blank})
                          && ({1'b0, r_argmax} != r_prev);
    assign o_stat.div_busy = (r_dstep != '0);
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank   <= '0;
            r_row_max <= '0;
            r_argmax  <= '0;
            r_cc      <= '0;
            r_sum     <= '0;
            r_prev    <= PREV_NONE;
            r_psum    <= '0;
            r_cnt     <= '0;
            r_dstep   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blank <= i_cfg_data;
            end
            if (i_cmd.update) begin
                if (fresh || gt) begin
                    r_row_max <= r_x;
                    r_argmax  <= r_cc;
                end
                r_sum <= fresh ? ONE_Q16 : s_sat;
                r_cc  <= (cc_inc >= (CLS_W+1)'(MAX_CLASSES)) ? '0 : cc_inc[CLS_W-1:0];
            end
            if (i_cmd.row_close || i_cmd.put_char) begin
                r_prev    <= {1'b0, r_argmax};
                r_row_max <= '0;
                r_argmax  <= '0;
                r_cc      <= '0;
                r_sum     <= '0;
            end
            if (i_cmd.put_char && (r_cnt < COUNT_MAX)) begin
                r_psum <= r_psum + PSUM_W'(q_sat);
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.put_sum) begin
                r_prev <= PREV_NONE;
                r_psum <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.div_char || i_cmd.div_mean) begin
                r_dstep <= DIV_STEPS;
            end else if (r_dstep != '0) begin
                r_dstep <= r_dstep - DSTEP_W'(1);
            end
            if (i_cmd.put_char || i_cmd.put_sum) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x        <= i_logit;
            r_row_done <= i_row_end || i_sequence_end;
            r_seq_end  <= i_sequence_end;
        end
        if (i_cmd.mul_exp) begin
            r_e <= e_val;
        end
        if (i_cmd.div_char) begin
            // 2^32 plus half the divisor, for a rounded reciprocal
            r_rem <= '0;
            r_num <= {1'b1, {(DIVN_W-1){1'b0}}} + {9'd0, 1'b0, r_sum[SUM_W-1:1]};
            r_den <= r_sum;
        end else if (i_cmd.div_mean) begin
            r_rem <= '0;
            r_num <= DIVN_W'(mean_num);
            r_den <= SUM_W'(r_cnt);
        end else if (r_dstep != '0) begin
            r_rem <= qbit ? SUM_W'(rem_sh - {1'b0, r_den}) : rem_sh[SUM_W-1:0];
            r_num <= {r_num[DIVN_W-2:0], qbit};
        end
        if (i_cmd.put_char) begin
            o_kind             <= 1'b0;
            o_class_index      <= r_argmax;
            o_char_probability <= q_sat;
            o_mean_confidence  <= '0;
            o_emitted_count    <= '0;
            o_last             <= 1'b0;
        end else if (i_cmd.put_sum) begin
            o_kind             <= 1'b1;
            o_class_index      <= '0;
            o_char_probability <= '0;
            o_mean_confidence  <= (r_cnt == '0) ? '0 : q_sat;
            o_emitted_count    <= r_cnt;
            o_last             <= 1'b1;
        end
    end

    a_sum_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_sum >= ONE_Q16))
        else $error("normaliser below one after update");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_char || i_cmd.div_mean) |-> (r_dstep == '0))
        else $error("divider restarted while busy");
    a_put_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_char || i_cmd.put_sum) |-> o_stat.out_free)
        else $error("output register overwritten");

endmodule

[rtl/core/ctc_greedy_decoder.sv]
// CTC greedy decoder with softmax confidence. Each request is one class
// logit (Q8.8); a row ends with row_end or sequence_end. Every logit passes
// through capture, exp table multiply, normaliser update and check; a row
// that emits a character also runs the 33-step restoring divider that
// forms 1/normaliser, and a sequence end runs it again for the mean
// division. Results wait in an output register; the next request is taken
// while a result is still held. Blank class is set through i_cfg_we/data.
// Depends on ctcgd_pkg, ctcgd_ctrl, ctcgd_dp.
`timescale 1ns / 1ps
module ctc_greedy_decoder import ctcgd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CLS_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_row_end,
    input  logic                      i_sequence_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [CLS_W-1:0]          o_class_index,
    output logic [PROB_W-1:0]         o_char_probability,
    output logic [PROB_W-1:0]         o_mean_confidence,
    output logic [CNT_W-1:0]          o_emitted_count,
    output logic                      o_last
);

    t_cmd  cmd;
    t_stat stat;

    ctcgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ctcgd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_logit            (i_logit),
        .i_row_end          (i_row_end),
        .i_sequence_end     (i_sequence_end),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_class_index      (o_class_index),
        .o_char_probability (o_char_probability),
        .o_mean_confidence  (o_mean_confidence),
        .o_emitted_count    (o_emitted_count),
        .o_last             (o_last)
    );

endmodule
